/* design/xcfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package xcfp_pkg;

    // Sequence and command bytes that precede the payload in every body.
    localparam int unsigned HEADER_BYTES = 2;

    // Hard cap on the payload of one frame; it bounds byte_index and the run.
    localparam int unsigned PAYLOAD_CAP = 32;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 6;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned CFG_A_W = 4;

    localparam logic [CFG_A_W-1:0] CFG_SOF_BYTE      = 4'd0;
    localparam logic [CFG_A_W-1:0] CFG_PAYLOAD_LIMIT = 4'd1;

    typedef enum logic [2:0] {
        PH_WAIT_SOF,
        PH_READ_LEN,
        PH_READ_BODY,
        PH_READ_CHK,
        PH_EMIT_RD,
        PH_EMIT_LD
    } phase_t;

endpackage

`default_nettype wire

/* design/xor_checked_frame_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------
// input     | in_valid / in_stall  | data_byte
// output    | out_valid / out_stall| seq, cmd, pld_len, has_payload,
//           |                      | payload_byte, byte_index, last
// config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Every received byte is accepted without a stall while the parser hunts, reads
// the length, the body or the checksum. After a frame whose checksum matches,
// the run is produced from the body memory one result at a time: a read state
// fetches the memory entry, then a load state fills the output register, waiting
// while out_stall holds the output register. Input requests are stalled only during the run.
// Reset returns the parser to hunting for the start byte; the body memory
// needs no clearing since every entry is written before a frame reads it.
module xor_checked_frame_parser
    import xcfp_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [BYTE_W-1:0]  data_byte,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [BYTE_W-1:0]       seq,
    output logic [BYTE_W-1:0]       cmd,
    output logic [LEN_W-1:0]        pld_len,
    output logic                    has_payload,
    output logic [BYTE_W-1:0]       payload_byte,
    output logic [IDX_W-1:0]        byte_index,
    output logic                    last,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_A_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]  cfg_data
);

    // The payload of a frame never exceeds the smaller of the build limit and
    // the hard cap, so the body memory only needs that many payload entries.
    localparam int unsigned LIM_CAP     = (MAX_PAYLOAD < PAYLOAD_CAP) ?
                                          MAX_PAYLOAD : PAYLOAD_CAP;
    localparam int unsigned STORE_DEPTH = LIM_CAP + HEADER_BYTES;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

    phase_t                 state_reg, state_next;
    logic [BYTE_W-1:0]      sof_reg;
    logic [LEN_W-1:0]       limit_reg;
    logic [LEN_W-1:0]       frame_len_reg, frame_len_next;
    logic [LEN_W-1:0]       body_cnt_reg, body_cnt_next;
    logic [BYTE_W-1:0]      xor_reg, xor_next;
    logic [BYTE_W-1:0]      seq_reg, seq_next;
    logic [BYTE_W-1:0]      cmd_reg, cmd_next;
    logic [IDX_W-1:0]       emit_idx_reg, emit_idx_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_load;
    logic [BYTE_W-1:0]      out_seq_reg, out_cmd_reg, out_byte_reg;
    logic [LEN_W-1:0]       out_len_reg;
    logic                   out_has_reg, out_last_reg;
    logic [IDX_W-1:0]       out_idx_reg;

    // Body memory: one write port for incoming body bytes, one registered
    // read port for the payload run.
    logic [BYTE_W-1:0]      body_mem [STORE_DEPTH];
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_wa;
    logic [ADDR_W-1:0]      mem_ra;
    logic [BYTE_W-1:0]      mem_rd_reg;

    logic                   in_acc;
    logic                   out_free;
    logic [LEN_W-1:0]       eff_limit;
    logic [BYTE_W-1:0]      len_max;
    logic [LEN_W-1:0]       plen;
    logic [LEN_W-1:0]       rd_pos;
    logic [LEN_W-1:0]       body_cnt_inc;
    logic                   run_last;

    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && !in_stall;
    // The output register can take a new result when it is empty or its
    // current result leaves in this cycle.
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        eff_limit = limit_reg;
        if (limit_reg > LEN_W'(LIM_CAP))
        begin
            eff_limit = LEN_W'(LIM_CAP);
        end
    end

    assign len_max      = BYTE_W'(eff_limit) + BYTE_W'(HEADER_BYTES);
    assign plen         = frame_len_reg - LEN_W'(HEADER_BYTES);
    assign rd_pos       = LEN_W'(emit_idx_reg) + LEN_W'(HEADER_BYTES);
    assign mem_ra       = rd_pos[ADDR_W-1:0];
    assign mem_wa       = body_cnt_reg[ADDR_W-1:0];
    assign body_cnt_inc = body_cnt_reg + 1'b1;
    assign run_last     = (LEN_W'(emit_idx_reg) + 1'b1) == plen;

    always_comb
    begin
        state_next     = state_reg;
        frame_len_next = frame_len_reg;
        body_cnt_next  = body_cnt_reg;
        xor_next       = xor_reg;
        seq_next       = seq_reg;
        cmd_next       = cmd_reg;
        emit_idx_next  = emit_idx_reg;
        in_stall       = 1'b0;
        mem_we         = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            PH_WAIT_SOF:
            begin
                if (in_acc && data_byte == sof_reg)
                begin
                    state_next = PH_READ_LEN;
                end
            end
            PH_READ_LEN:
            begin
                if (in_acc)
                begin
                    if (data_byte < BYTE_W'(HEADER_BYTES) || data_byte > len_max)
                    begin
                        state_next = PH_WAIT_SOF;
                    end
                    else
                    begin
                        frame_len_next = data_byte[LEN_W-1:0];
                        body_cnt_next  = '0;
                        xor_next       = data_byte;
                        state_next     = PH_READ_BODY;
                    end
                end
            end
            PH_READ_BODY:
            begin
                if (in_acc)
                begin
                    mem_we        = 1'b1;
                    xor_next      = xor_reg ^ data_byte;
                    body_cnt_next = body_cnt_inc;
                    if (body_cnt_reg == '0)
                    begin
                        seq_next = data_byte;
                    end
                    if (body_cnt_reg == LEN_W'(1))
                    begin
                        cmd_next = data_byte;
                    end
                    if (body_cnt_inc >= frame_len_reg)
                    begin
                        state_next = PH_READ_CHK;
                    end
                end
            end
            PH_READ_CHK:
            begin
                if (in_acc)
                begin
                    emit_idx_next = '0;
                    if (xor_reg == data_byte)
                    begin
                        state_next = PH_EMIT_RD;
                    end
                    else
                    begin
                        state_next = PH_WAIT_SOF;
                    end
                end
            end
            PH_EMIT_RD:
            begin
                // The read of the current payload entry is under way.
                in_stall   = 1'b1;
                state_next = PH_EMIT_LD;
            end
            PH_EMIT_LD:
            begin
                in_stall = 1'b1;
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (plen == '0 || run_last)
                    begin
                        state_next = PH_WAIT_SOF;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                        state_next    = PH_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = PH_WAIT_SOF;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_WAIT_SOF;
            sof_reg       <= 8'd170;
            limit_reg     <= LEN_W'(PAYLOAD_CAP);
            frame_len_reg <= '0;
            body_cnt_reg  <= '0;
            xor_reg       <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_len_reg <= frame_len_next;
            body_cnt_reg  <= body_cnt_next;
            xor_reg       <= xor_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SOF_BYTE)
                begin
                    sof_reg <= cfg_data;
                end
                else if (cfg_index == CFG_PAYLOAD_LIMIT)
                begin
                    limit_reg <= cfg_data[LEN_W-1:0];
                end
            end
        end
    end

    // Header bytes and the output payload carry no reset.
    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
        cmd_reg <= cmd_next;
        if (out_load)
        begin
            out_seq_reg <= seq_reg;
            out_cmd_reg <= cmd_reg;
            out_len_reg <= plen;
            if (plen == '0)
            begin
                out_has_reg  <= 1'b0;
                out_byte_reg <= '0;
                out_idx_reg  <= '0;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_has_reg  <= 1'b1;
                out_byte_reg <= mem_rd_reg;
                out_idx_reg  <= emit_idx_reg;
                out_last_reg <= run_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            body_mem[mem_wa] <= data_byte;
        end
        mem_rd_reg <= body_mem[mem_ra];
    end

    assign out_valid    = out_valid_reg;
    assign seq          = out_seq_reg;
    assign cmd          = out_cmd_reg;
    assign pld_len      = out_len_reg;
    assign has_payload  = out_has_reg;
    assign payload_byte = out_byte_reg;
    assign byte_index   = out_idx_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire
